/* sv/load_cell_moving_average_assert.svh */
// Assertion macros for the load-cell moving-average RTL.
`ifndef LOAD_CELL_MOVING_AVERAGE_ASSERT_SVH
`define LOAD_CELL_MOVING_AVERAGE_ASSERT_SVH

// Condition must never hold outside reset.
`define LCMA_ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define LCMA_ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define LCMA_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/lcma_pkg.sv */
// Package for the load-cell moving average: widths, defaults and control and status structs.
`default_nettype none

package lcma_pkg;

	localparam int DEPTH_BITS      = 7;
	localparam int OUT_BITS        = 32;
	localparam int FRAC_BITS       = 8;
	localparam int DEF_MAX_DEPTH   = 64;
	localparam int DEF_SAMPLE_BITS = 24;
	localparam logic [DEPTH_BITS-1:0] DEPTH_RESET = 7'd1;

	typedef struct packed {
		logic clear;
		logic rd_en;
		logic upd_en;
	} lcma_ring_ctrl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} lcma_div_stat_t;

endpackage

`default_nettype wire

/* sv/load_cell_moving_average.sv */
// Top level of the load-cell moving-average filter: sequencer and stream ports.
//
// One signed sample enters on s_tvalid/s_tready/s_tdata; one filtered value
// (signed, 8 fraction bits, truncated toward zero) leaves on m_tvalid/m_tready/m_tdata.
// cfg_we with cfg_wdata sets the window depth; each write clears the wrap flag,
// the running sum and the write slot. Depth 0 passes sample * 256 through.
// Write the depth only while no request is in flight.
// Sequence: pass-through goes from idle straight to the done state; averaging reads
// the ring on acceptance, then S_READ updates the ring and starts the divider and
// S_DIV waits for the one-bit-per-cycle restoring divider (NW = SAMPLE_BITS +
// clog2(MAX_DEPTH) + 9 quotient bits); the done state then loads the output register.
// s_tready is high only while the sequencer is idle, so one request is in work at a time;
// a finished result waits in the output register while the next request is taken.
// If the receiver stalls, the finished value waits in a hold state until the
// output register frees up.
// Reset: depth 1, ring treated as all zero (a wrap flag gates reads, no clearing pass),
// no output pending.
`default_nettype none
`include "load_cell_moving_average_assert.svh"

module load_cell_moving_average import lcma_pkg::*; #(
	parameter int MAX_DEPTH   = DEF_MAX_DEPTH,
	parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
	localparam int IN_W = ((SAMPLE_BITS + 7) / 8) * 8
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   cfg_we,
	input  wire  [DEPTH_BITS-1:0] cfg_wdata,
	input  wire                   s_tvalid,
	output logic                  s_tready,
	input  wire  [IN_W-1:0]       s_tdata,   // [SAMPLE_BITS-1:0] sample
	output logic                  m_tvalid,
	input  wire                   m_tready,
	output logic [OUT_BITS-1:0]   m_tdata    // [31:0] average
);

	localparam int AW    = $clog2(MAX_DEPTH);
	localparam int SUM_W = SAMPLE_BITS + AW + 1;
	localparam int NW    = SUM_W + FRAC_BITS;
	localparam int RW    = (NW + 1 > OUT_BITS) ? NW + 1 : OUT_BITS;
	localparam int PW    = SAMPLE_BITS + FRAC_BITS;
	localparam int PRW   = (PW > OUT_BITS) ? PW : OUT_BITS;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_READ = 2'd1;
	localparam logic [1:0] S_DIV  = 2'd2;
	localparam logic [1:0] S_DONE = 2'd3;

	logic [1:0]                    state_q;
	logic [DEPTH_BITS-1:0]         depth_q;
	logic [DEPTH_BITS-1:0]         eff_depth;
	logic signed [SAMPLE_BITS-1:0] sample_q;
	logic signed [SAMPLE_BITS-1:0] in_sample;
	logic [OUT_BITS-1:0]           res_q;
	logic [OUT_BITS-1:0]           out_q;
	logic                          out_valid_q;
	logic                          accept;
	logic                          pass_acc;
	logic                          avg_acc;
	logic                          out_free;
	lcma_ring_ctrl_t               ring_ctrl;
	logic signed [SUM_W-1:0]       sum_next;
	logic signed [NW-1:0]          num;
	logic                          num_neg;
	logic [NW-1:0]                 num_mag;
	lcma_div_stat_t                div_stat;
	logic signed [NW:0]            quot;
	logic signed [RW-1:0]          quot_ext;
	logic signed [PW-1:0]          pass_w;
	logic signed [PRW-1:0]         pass_ext;

	assign in_sample = $signed(s_tdata[SAMPLE_BITS-1:0]);
	assign eff_depth = (32'(depth_q) > MAX_DEPTH) ? DEPTH_BITS'(MAX_DEPTH) : depth_q;
	assign s_tready  = (state_q == S_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign pass_acc  = accept && (eff_depth == '0);
	assign avg_acc   = accept && (eff_depth != '0);
	assign out_free  = !out_valid_q || m_tready;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = out_q;

	assign pass_w   = {in_sample, FRAC_BITS'(0)};
	assign pass_ext = PRW'(pass_w);

	assign ring_ctrl.clear  = cfg_we;
	assign ring_ctrl.rd_en  = avg_acc;
	assign ring_ctrl.upd_en = (state_q == S_READ);

	assign num      = {sum_next, FRAC_BITS'(0)};
	assign num_neg  = sum_next[SUM_W-1];
	assign num_mag  = num_neg ? NW'(-num) : NW'(num);
	assign quot_ext = RW'(quot);

	lcma_ring #(
		.MAX_DEPTH  (MAX_DEPTH),
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_ring (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (ring_ctrl),
		.depth   (eff_depth),
		.sample  (sample_q),
		.sum_next(sum_next)
	);

	lcma_div #(
		.NW(NW)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == S_READ),
		.num_mag(num_mag),
		.neg    (num_neg),
		.divisor(eff_depth),
		.stat   (div_stat),
		.quot   (quot)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_q <= in_sample;
			res_q    <= pass_ext[OUT_BITS-1:0];
		end else if (state_q == S_DIV && div_stat.done) begin
			res_q <= quot_ext[OUT_BITS-1:0];
		end
		if (state_q == S_DONE && out_free) begin
			out_q <= res_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= DEPTH_RESET;
		end else if (cfg_we) begin
			depth_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= (eff_depth == '0) ? S_DONE : S_READ;
					end
				end
				S_READ: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (div_stat.done) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`LCMA_ASSERT_NEVER(a_ready_while_div, clk, arst_n, s_tready && div_stat.busy, "ready in divide")
	`LCMA_ASSERT_IMPLY(a_done_in_div, clk, arst_n, div_stat.done, state_q == S_DIV, "stray done")
	`LCMA_ASSERT_NEXT(a_pass_done, clk, arst_n, pass_acc, state_q == S_DONE, "pass-through late")
	`LCMA_ASSERT_NEXT(a_avg_start, clk, arst_n, avg_acc, state_q == S_READ, "no ring read")

endmodule

`default_nettype wire

/* sv/lcma_ring.sv */
// Sample ring memory with write slot, wrap flag and running window sum.
`default_nettype none

module lcma_ring import lcma_pkg::*; #(
	parameter int MAX_DEPTH   = DEF_MAX_DEPTH,
	parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
	localparam int AW    = $clog2(MAX_DEPTH),
	localparam int SUM_W = SAMPLE_BITS + AW + 1
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  lcma_ring_ctrl_t              ctrl,
	input  wire        [DEPTH_BITS-1:0]  depth,
	input  wire signed [SAMPLE_BITS-1:0] sample,
	output logic signed [SUM_W-1:0]      sum_next
);

	localparam int CW = ((AW > DEPTH_BITS) ? AW : DEPTH_BITS) + 1;

	logic signed [SAMPLE_BITS-1:0] mem [MAX_DEPTH];
	logic signed [SAMPLE_BITS-1:0] rd_q;
	logic        [AW-1:0]          slot_q;
	logic                          wrapped_q;
	logic signed [SUM_W-1:0]       sum_q;
	logic signed [SAMPLE_BITS-1:0] old_val;
	logic                          last;

	// entry at the write slot holds data only once the ring has wrapped
	assign old_val  = wrapped_q ? rd_q : '0;
	assign sum_next = sum_q - SUM_W'(old_val) + SUM_W'(sample);
	assign last     = (CW'(slot_q) + CW'(1)) == CW'(depth);

	always_ff @(posedge clk) begin
		if (ctrl.rd_en) begin
			rd_q <= mem[slot_q];
		end
		if (ctrl.upd_en) begin
			mem[slot_q] <= sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q    <= '0;
			wrapped_q <= 1'b0;
			sum_q     <= '0;
		end else if (ctrl.clear) begin
			slot_q    <= '0;
			wrapped_q <= 1'b0;
			sum_q     <= '0;
		end else if (ctrl.upd_en) begin
			sum_q     <= sum_next;
			slot_q    <= last ? '0 : slot_q + AW'(1);
			wrapped_q <= wrapped_q | last;
		end
	end

endmodule

`default_nettype wire

/* sv/lcma_div.sv */
// Bit-serial restoring divider for the signed window sum by the window depth.
`default_nettype none

module lcma_div import lcma_pkg::*; #(
	parameter int NW = DEF_SAMPLE_BITS + $clog2(DEF_MAX_DEPTH) + 1 + FRAC_BITS
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     start,
	input  wire  [NW-1:0]           num_mag,
	input  wire                     neg,
	input  wire  [DEPTH_BITS-1:0]   divisor,
	output lcma_div_stat_t          stat,
	output logic signed [NW:0]      quot
);

	localparam int CNTW = $clog2(NW);

	logic [NW-1:0]         quot_q;
	logic [DEPTH_BITS-1:0] rem_q;
	logic [DEPTH_BITS-1:0] dvs_q;
	logic [CNTW-1:0]       cnt_q;
	logic                  neg_q;
	logic                  busy_q;
	logic                  done_q;
	logic [DEPTH_BITS+1:0] trial;
	logic                  ge;
	logic [DEPTH_BITS-1:0] rem_next;

	assign trial    = {1'b0, rem_q, quot_q[NW-1]} - {2'b00, dvs_q};
	assign ge       = !trial[DEPTH_BITS+1];
	assign rem_next = ge ? trial[DEPTH_BITS-1:0] : {rem_q[DEPTH_BITS-2:0], quot_q[NW-1]};

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quot      = neg_q ? -$signed({1'b0, quot_q}) : $signed({1'b0, quot_q});

	always_ff @(posedge clk) begin
		if (start) begin
			quot_q <= num_mag;
			rem_q  <= '0;
			dvs_q  <= divisor;
			neg_q  <= neg;
			cnt_q  <= CNTW'(NW - 1);
		end else if (busy_q) begin
			quot_q <= {quot_q[NW-2:0], ge};
			rem_q  <= rem_next;
			cnt_q  <= cnt_q - CNTW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

/* tb/sv/tb.sv */
// Self-checking testbench for the load-cell moving-average filter.
`timescale 1ns / 1ps

module tb;
	import lcma_pkg::*;

	localparam int SAMPLE_W  = DEF_SAMPLE_BITS;
	localparam int IDLE_PCT  = 12;
	localparam int DRAIN_CYC = 60;
	localparam int HOLD_CYC  = 300;
	localparam int HOLD_AT   = 400;
	localparam int RAND_ITEMS = 1250;
	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [DEPTH_BITS-1:0] cfg_wdata;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [SAMPLE_W-1:0]   s_tdata;   // [23:0] sample
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_BITS-1:0]   m_tdata;   // [31:0] average

	load_cell_moving_average dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	// filter state mirror
	longint                window_ring [DEF_MAX_DEPTH];
	int                    ring_slot;
	longint                running_sum;
	logic [DEPTH_BITS-1:0] depth_setting;

	logic [SAMPLE_W-1:0]   pending_samples [$];
	logic [OUT_BITS-1:0]   expected_averages [$];
	int                    failures = 0;
	int                    results_seen = 0;
	int                    hold_left = 0;
	bit                    hold_done = 1'b0;
	bit                    steady;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic void clear_window_state();
		foreach (window_ring[i]) window_ring[i] = 0;
		ring_slot = 0;
		running_sum = 0;
	endfunction

	function automatic logic [OUT_BITS-1:0] predict_average(logic signed [SAMPLE_W-1:0] smp);
		int     eff;
		longint scaled;
		if (depth_setting == 0) begin
			scaled = longint'(smp) * (longint'(1) << FRAC_BITS);
		end else begin
			eff = (depth_setting > DEF_MAX_DEPTH) ? DEF_MAX_DEPTH : int'(depth_setting);
			if (ring_slot >= eff)
				ring_slot = 0;
			running_sum = running_sum - window_ring[ring_slot] + longint'(smp);
			window_ring[ring_slot] = longint'(smp);
			ring_slot = (ring_slot + 1) % eff;
			scaled = (running_sum * (longint'(1) << FRAC_BITS)) / longint'(eff);
		end
		return scaled[OUT_BITS-1:0];
	endfunction

	function automatic logic [SAMPLE_W-1:0] random_sample();
		case ($urandom_range(3))
			0: return ($urandom_range(1)) ? SAMPLE_MAX : SAMPLE_MIN;
			1: return SAMPLE_W'($urandom_range(600)) - SAMPLE_W'(300);
			default: return SAMPLE_W'($urandom());
		endcase
	endfunction

	// request side
	always @(posedge clk or negedge arst_n) begin
		logic                next_valid;
		logic [SAMPLE_W-1:0] next_data;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
		end else begin
			next_valid = s_tvalid;
			next_data  = s_tdata;
			if (s_tvalid && s_tready) begin
				expected_averages.push_back(predict_average(s_tdata));
				next_valid = 1'b0;
			end
			if (!next_valid && pending_samples.size() != 0 &&
			    (steady || $urandom_range(99) >= IDLE_PCT)) begin
				next_valid = 1'b1;
				next_data  = pending_samples.pop_front();
			end
			s_tvalid <= next_valid;
			s_tdata  <= next_data;
		end
	end

	// result side
	always @(posedge clk or negedge arst_n) begin
		logic [OUT_BITS-1:0] want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				results_seen++;
				if (expected_averages.size() == 0) begin
					$error("average: no request outstanding, actual %0d", $signed(m_tdata));
					failures++;
				end else begin
					want = expected_averages.pop_front();
					if (m_tdata !== want) begin
						$error("average: expected %0d actual %0d",
						       $signed(want), $signed(m_tdata));
						failures++;
					end
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (!hold_done && results_seen >= HOLD_AT) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYC;
				m_tready <= 1'b0;
			end else begin
				m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	task automatic wait_drained();
		while (pending_samples.size() != 0 || s_tvalid || expected_averages.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);
	endtask

	task automatic write_depth(input logic [DEPTH_BITS-1:0] d);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= d;
		depth_setting = d;
		clear_window_state();
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic push_samples(input logic [SAMPLE_W-1:0] list []);
		foreach (list[i]) pending_samples.push_back(list[i]);
	endtask

	initial begin
		int                    sent;
		int                    phase;
		int                    count;
		logic [DEPTH_BITS-1:0] d;
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_wdata = '0;
		steady    = 1'b0;
		depth_setting = DEPTH_RESET;
		clear_window_state();
		repeat (10) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// reset depth, then pass-through, truncation, maximum depth, saturated depth
		push_samples('{SAMPLE_MAX, SAMPLE_MIN, '1});
		wait_drained();
		write_depth(0);
		push_samples('{SAMPLE_MIN, SAMPLE_MAX, '0, '1, 24'd1});
		wait_drained();
		write_depth(3);
		push_samples('{'1, '0, '0, 24'd5, SAMPLE_MIN});
		wait_drained();
		write_depth(DEF_MAX_DEPTH);
		push_samples('{SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MIN});
		wait_drained();
		write_depth('1);
		push_samples('{SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN});
		wait_drained();

		sent  = 0;
		phase = 0;
		while (sent < RAND_ITEMS) begin
			case (phase)
				0: d = 1;
				1: d = DEF_MAX_DEPTH;
				2: d = 0;
				3: d = '1;
				4: d = 2;
				5: d = d; // same value again still clears the window
				default: d = ($urandom_range(3) == 0) ? DEPTH_BITS'($urandom_range(127)) :
				                                        DEPTH_BITS'($urandom_range(64));
			endcase
			steady = (phase == 3);
			write_depth(d);
			count = $urandom_range(60, 140);
			repeat (count) pending_samples.push_back(random_sample());
			sent += count;
			phase++;
			wait_drained();
		end
		steady = 1'b0;

		if (failures == 0)
			$display("load_cell_moving_average regression: pass");
		else
			$display("load_cell_moving_average regression: fail");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("load_cell_moving_average regression: fail");
		$finish;
	end

endmodule
